[src/rmq_pkg.sv]
// Shared types and constants for the rotation-matrix-to-quaternion block.
`default_nettype none

package rmq_pkg;

  // Fixed field widths
  localparam int IN_W  = 16;
  localparam int XYZ_W = 16;
  localparam int W_W   = 15;

  // One square-root lane per quaternion component
  localparam int LANES = 4;

  // Input transaction: 3x3 matrix, signed Q1.14, row then column
  typedef struct packed {
    logic signed [IN_W-1:0] r00;
    logic signed [IN_W-1:0] r01;
    logic signed [IN_W-1:0] r02;
    logic signed [IN_W-1:0] r10;
    logic signed [IN_W-1:0] r11;
    logic signed [IN_W-1:0] r12;
    logic signed [IN_W-1:0] r20;
    logic signed [IN_W-1:0] r21;
    logic signed [IN_W-1:0] r22;
  } matrix_t;

  // Output transaction: unit quaternion, Q1.14
  typedef struct packed {
    logic signed [XYZ_W-1:0] quat_x;
    logic signed [XYZ_W-1:0] quat_y;
    logic signed [XYZ_W-1:0] quat_z;
    logic [W_W-1:0]          quat_w;
  } quat_t;

endpackage

`default_nettype wire

[src/rmq_isqrt.sv]
// Pipelined four-lane integer square root, one result bit per stage.
`default_nettype none

module rmq_isqrt #(
  parameter int IN_W  = 29,
  parameter int TAG_W = 3,
  localparam int NB   = (IN_W + 1) / 2
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  input  wire logic [rmq_pkg::LANES-1:0][IN_W-1:0]  in_val,
  input  wire logic [TAG_W-1:0]                     in_tag,
  output logic                                      out_valid,
  output logic [rmq_pkg::LANES-1:0][NB-1:0]         out_root,
  output logic [TAG_W-1:0]                          out_tag
);

  localparam int LANES = rmq_pkg::LANES;
  localparam int PAD_W = 2 * NB;   // radicand padded to whole bit pairs
  localparam int REM_W = NB + 1;   // remainder stays at or below twice the root
  localparam int SH_W  = NB + 3;   // remainder with the next bit pair appended

  // Stage registers: index s holds the state after step s
  logic [NB-1:0]                          vld_q, vld_n;
  logic [NB-1:0][TAG_W-1:0]               tag_q, tag_n;
  logic [NB-1:0][LANES-1:0][PAD_W-1:0]    val_q, val_n;
  logic [NB-1:0][LANES-1:0][REM_W-1:0]    rem_q, rem_n;
  logic [NB-1:0][LANES-1:0][NB-1:0]       root_q, root_n;

  // Stage inputs: step 0 takes the ports, later steps the previous register
  logic [NB-1:0]                          vld_i;
  logic [NB-1:0][TAG_W-1:0]               tag_i;
  logic [NB-1:0][LANES-1:0][PAD_W-1:0]    val_i;
  logic [NB-1:0][LANES-1:0][REM_W-1:0]    rem_i;
  logic [NB-1:0][LANES-1:0][NB-1:0]       root_i;

  always_comb begin
    vld_i[0] = in_valid;
    tag_i[0] = in_tag;
    for (int l = 0; l < LANES; l++) begin
      val_i[0][l]  = PAD_W'(in_val[l]);
      rem_i[0][l]  = '0;
      root_i[0][l] = '0;
    end
    for (int s = 1; s < NB; s++) begin
      vld_i[s]  = vld_q[s-1];
      tag_i[s]  = tag_q[s-1];
      val_i[s]  = val_q[s-1];
      rem_i[s]  = rem_q[s-1];
      root_i[s] = root_q[s-1];
    end
  end

  // One restoring step per stage: bring down two bits, try root*4+1
  always_comb begin
    logic [SH_W-1:0] sh;
    logic [SH_W-1:0] trial;
    logic [SH_W-1:0] diff;
    logic            ge;
    for (int s = 0; s < NB; s++) begin
      vld_n[s] = vld_i[s];
      tag_n[s] = tag_i[s];
      for (int l = 0; l < LANES; l++) begin
        sh    = {rem_i[s][l], val_i[s][l][PAD_W-1 -: 2]};
        trial = {1'b0, root_i[s][l], 2'b01};
        diff  = sh - trial;
        ge    = (sh >= trial);
        rem_n[s][l]  = ge ? diff[REM_W-1:0] : sh[REM_W-1:0];
        root_n[s][l] = {root_i[s][l][NB-2:0], ge};
        val_n[s][l]  = {val_i[s][l][PAD_W-3:0], 2'b00};
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_n;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    tag_q  <= tag_n;
    val_q  <= val_n;
    rem_q  <= rem_n;
    root_q <= root_n;
  end

  assign out_valid = vld_q[NB-1];
  assign out_root  = root_q[NB-1];
  assign out_tag   = tag_q[NB-1];

endmodule

`default_nettype wire

[src/rotation_matrix_to_quaternion_top.sv]
// Top level: rotation matrix to unit quaternion, fully pipelined.
// A matrix is taken at every clock edge where start is high; busy is always low, so a new
// transaction may enter each cycle. The quaternion appears on result, with done high for
// exactly one cycle, once the transaction has passed a stage that forms the radicands,
// the square-root pipeline, which resolves one root bit per stage in four parallel lanes,
// and a stage that saturates, signs and registers the result. Transactions leave in
// the order they entered, one per cycle at most, and cannot be held off.
`default_nettype none

module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire rmq_pkg::matrix_t matrix,
  output logic                 done,
  output rmq_pkg::quat_t       result
);

  localparam int IN_W  = rmq_pkg::IN_W;
  localparam int XYZ_W = rmq_pkg::XYZ_W;
  localparam int W_W   = rmq_pkg::W_W;
  localparam int LANES = rmq_pkg::LANES;

  // Radicand range: one plus or minus three full-scale inputs
  localparam longint RAD_MAX = (longint'(1) << FRAC_BITS) + 3 * (longint'(1) << (IN_W - 1));
  localparam int RAD_W   = $clog2(RAD_MAX + 1) + 1;
  localparam int MAGN_W  = RAD_W - 1;
  localparam int SQ_IN_W = MAGN_W + FRAC_BITS - 2;
  localparam int SQ_NB   = (SQ_IN_W + 1) / 2;
  localparam int CMP_W   = (SQ_NB > FRAC_BITS) ? SQ_NB : FRAC_BITS + 1;
  localparam int LAT     = SQ_NB + 2;

  // Lane and sign-tag positions
  localparam int LANE_W = 0;
  localparam int LANE_X = 1;
  localparam int LANE_Y = 2;
  localparam int LANE_Z = 3;
  localparam int TAG_W  = 3;
  localparam int TAG_X  = 0;
  localparam int TAG_Y  = 1;
  localparam int TAG_Z  = 2;

  localparam logic signed [RAD_W-1:0] ONE = RAD_W'(longint'(1) << FRAC_BITS);
  localparam logic [CMP_W-1:0] ONE_MAG    = CMP_W'(longint'(1) << FRAC_BITS);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Radicands from the diagonal, signs from the off-diagonal differences
  logic signed [RAD_W-1:0]                 e00, e11, e22;
  logic signed [LANES-1:0][RAD_W-1:0]      rad_c;
  logic [LANES-1:0][SQ_IN_W-1:0]           sq_val_c;
  logic [TAG_W-1:0]                        tag_c;

  assign e00 = RAD_W'(matrix.r00);
  assign e11 = RAD_W'(matrix.r11);
  assign e22 = RAD_W'(matrix.r22);

  always_comb begin
    rad_c[LANE_W] = ONE + e00 + e11 + e22;
    rad_c[LANE_X] = ONE + e00 - e11 - e22;
    rad_c[LANE_Y] = ONE - e00 + e11 - e22;
    rad_c[LANE_Z] = ONE - e00 - e11 + e22;
    // Clamp negative radicands, scale by 2^(FRAC_BITS-2) for the half root
    for (int l = 0; l < LANES; l++) begin
      sq_val_c[l] = rad_c[l][RAD_W-1] ? '0
                    : {rad_c[l][MAGN_W-1:0], {(FRAC_BITS - 2){1'b0}}};
    end
    tag_c[TAG_X] = (matrix.r21 < matrix.r12);
    tag_c[TAG_Y] = (matrix.r02 < matrix.r20);
    tag_c[TAG_Z] = (matrix.r10 < matrix.r01);
  end

  // Stage 1 registers
  logic                          s1_valid;
  logic [LANES-1:0][SQ_IN_W-1:0] s1_val;
  logic [TAG_W-1:0]              s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_val <= sq_val_c;
    s1_tag <= tag_c;
  end

  // Square-root pipeline
  logic                        sq_valid;
  logic [LANES-1:0][SQ_NB-1:0] sq_root;
  logic [TAG_W-1:0]            sq_tag;

  rmq_isqrt #(
    .IN_W  (SQ_IN_W),
    .TAG_W (TAG_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_val    (s1_val),
    .in_tag    (s1_tag),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // Saturate to one, apply signs, trim to field widths
  logic [LANES-1:0][CMP_W-1:0] mag_c;
  rmq_pkg::quat_t              quat_c;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag_c[l] = (CMP_W'(sq_root[l]) > ONE_MAG) ? ONE_MAG : CMP_W'(sq_root[l]);
    end
    quat_c.quat_x = sq_tag[TAG_X] ? XYZ_W'(0) - XYZ_W'(mag_c[LANE_X]) : XYZ_W'(mag_c[LANE_X]);
    quat_c.quat_y = sq_tag[TAG_Y] ? XYZ_W'(0) - XYZ_W'(mag_c[LANE_Y]) : XYZ_W'(mag_c[LANE_Y]);
    quat_c.quat_z = sq_tag[TAG_Z] ? XYZ_W'(0) - XYZ_W'(mag_c[LANE_Z]) : XYZ_W'(mag_c[LANE_Z]);
    quat_c.quat_w = W_W'(mag_c[LANE_W]);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= quat_c;
  end

  // Every accepted transaction yields a result strobe on done
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted transaction produced no result after LAT cycles");

  // No result without a matching earlier accepted transaction
  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted transaction");

endmodule

`default_nettype wire
